// ===== rtl/ledbpp_pkg.sv =====
// Shared types, constants and helper functions of the LED blink pattern player.
package ledbpp_pkg;

	localparam int NUM_PATTERNS = 8;
	localparam int MAX_STEPS    = 16;
	localparam int SLOT_W       = $clog2(NUM_PATTERNS);
	localparam int STEP_W       = $clog2(MAX_STEPS);
	localparam int LEN_W        = $clog2(MAX_STEPS + 1);
	localparam int ADDR_W       = SLOT_W + STEP_W;
	localparam int STORE_DEPTH  = NUM_PATTERNS * MAX_STEPS;
	localparam int DUR_W        = 16;
	localparam int HOLD_W       = 12;

	// Hold ticks are |duration| / HOLD_DIVISOR, done as a multiply by the
	// reciprocal; exact for every 16-bit magnitude.
	localparam int HOLD_DIVISOR = 10;
	localparam int HOLD_RECIP   = 52429;
	localparam int HOLD_SHIFT   = 19;
	localparam int PROD_W       = 33;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_SET_BASE   = 3'd1,
		OP_SIGNAL     = 3'd2,
		OP_WRITE_STEP = 3'd3,
		OP_WRITE_LEN  = 3'd4
	} op_t;

	// What the second stage does to the LED and the hold counter.
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_DECR = 2'd1,
		ACT_OFF  = 2'd2,
		ACT_LOAD = 2'd3
	} act_t;

	typedef struct packed {
		act_t              act;
		logic              playing;
		logic              sig_valid;
		logic [STEP_W-1:0] step;
	} plan_t;

	typedef struct packed {
		logic              lit;
		logic              playing;
		logic              sig_valid;
		logic [STEP_W-1:0] step;
	} res_t;

	function automatic logic [DUR_W-1:0] dur_mag(input logic [DUR_W-1:0] raw);
		return raw[DUR_W-1] ? (~raw + DUR_W'(1)) : raw;
	endfunction

	function automatic logic [HOLD_W-1:0] hold_ticks(input logic [DUR_W-1:0] mag);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(mag) * PROD_W'(HOLD_RECIP);
		return prod[HOLD_SHIFT +: HOLD_W];
	endfunction

endpackage

// ===== rtl/led_blink_pattern_player.sv =====
// Top level of the LED blink pattern player: stream ports, pipeline control, assertions.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: 32 bits of command fields
// m_*       out  m_tvalid/m_tready  m_tdata: 8 bits of LED and player status
// cfg_*     in   cfg_we             cfg_wdata: active pin level
//
// Every command transfer yields exactly one status transfer, via the second stage
// and the output register. The block takes one command per cycle unless the
// output stalls: the first stage decides the next step and issues the store
// read, the second stage turns the read duration into the LED state and hold
// count, then the output register. Reset clears all control state and the
// pattern lengths; the step store itself holds whatever was written. A stalled
// output holds the second stage, and the input then waits until it can move.
module led_blink_pattern_player (
	input  logic                              clk,
	input  logic                              arst_n,
	// opcode[2:0], pattern_sel[5:3], no_pattern[6], entry_index[10:7],
	// entry_value[26:11], length_value[31:27]
	input  logic [ledbpp_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// led_pin[0], led_on[1], running[2], signal_active[3], step_position[7:4]
	output logic [ledbpp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata
);

	ledbpp_pkg::op_t                   opcode;
	logic [ledbpp_pkg::SLOT_W-1:0]     pattern_sel;
	logic                              no_pattern;
	logic [ledbpp_pkg::STEP_W-1:0]     entry_index;
	logic signed [ledbpp_pkg::DUR_W-1:0] entry_value;
	logic [ledbpp_pkg::LEN_W-1:0]      length_value;

	logic                              accept;
	logic                              advance;
	logic                              commit;
	logic                              valid_s1;
	logic                              out_valid_q;
	logic [ledbpp_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                              active_level_q;

	ledbpp_pkg::plan_t                 plan;
	ledbpp_pkg::res_t                  res;
	logic                              hold_le1;
	logic                              rd_en;
	logic [ledbpp_pkg::ADDR_W-1:0]     rd_addr;
	logic [ledbpp_pkg::DUR_W-1:0]      rdata;
	logic                              st_we;
	logic                              led_pin;

	assign opcode       = ledbpp_pkg::op_t'(s_tdata[2:0]);
	assign pattern_sel  = s_tdata[5:3];
	assign no_pattern   = s_tdata[6];
	assign entry_index  = s_tdata[10:7];
	assign entry_value  = s_tdata[26:11];
	assign length_value = s_tdata[31:27];

	// The second stage moves whenever the output register is empty or drained.
	assign advance  = !out_valid_q || m_tready;
	assign commit   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// Step writes go straight into the store at transfer time, so the next
	// command already reads the new value.
	assign st_we = accept && (opcode == ledbpp_pkg::OP_WRITE_STEP) &&
		(32'(pattern_sel) < ledbpp_pkg::NUM_PATTERNS) &&
		(32'(entry_index) < ledbpp_pkg::MAX_STEPS);

	ledbpp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (opcode),
		.sel          (pattern_sel),
		.no_pattern   (no_pattern),
		.length_value (length_value),
		.hold_le1     (hold_le1),
		.plan         (plan),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr)
	);

	ledbpp_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr ({pattern_sel, entry_index}),
		.wdata (entry_value),
		.re    (accept && rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	ledbpp_resolve u_resolve (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.plan_in  (plan),
		.valid_s1 (valid_s1),
		.commit   (commit),
		.rdata    (rdata),
		.res      (res),
		.hold_le1 (hold_le1)
	);

	assign led_pin = res.lit ? active_level_q : !active_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			active_level_q <= 1'b1;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (cfg_we) begin
				active_level_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {res.step, res.sig_valid, res.playing, res.lit, led_pin};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The LED is never reported lit while no pattern is being timed.
	a_lit_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2] || !m_tdata[1]))
		else $error("LED lit while player is stopped");

	// A finished second-stage item always shows up at the output next cycle.
	a_commit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("committed status transfer lost");

	// An empty output register never blocks the command side.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

// ===== rtl/ledbpp_store.sv =====
// Pattern step store: one write port, one read port with registered read data.
module ledbpp_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ledbpp_pkg::ADDR_W-1:0] waddr,
	input  logic [ledbpp_pkg::DUR_W-1:0]  wdata,
	input  logic                          re,
	input  logic [ledbpp_pkg::ADDR_W-1:0] raddr,
	output logic [ledbpp_pkg::DUR_W-1:0]  rdata
);

	logic [ledbpp_pkg::DUR_W-1:0] mem [ledbpp_pkg::STORE_DEPTH];
	logic [ledbpp_pkg::DUR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ledbpp_ctrl.sv =====
// Front stage: pattern selection, step sequencing, length table and store read address.
module ledbpp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  ledbpp_pkg::op_t               op,
	input  logic [ledbpp_pkg::SLOT_W-1:0] sel,
	input  logic                          no_pattern,
	input  logic [ledbpp_pkg::LEN_W-1:0]  length_value,
	input  logic                          hold_le1,
	output ledbpp_pkg::plan_t             plan,
	output logic                          rd_en,
	output logic [ledbpp_pkg::ADDR_W-1:0] rd_addr
);

	logic [ledbpp_pkg::SLOT_W-1:0] base_slot_q;
	logic                          base_valid_q;
	logic [ledbpp_pkg::SLOT_W-1:0] sig_slot_q;
	logic                          sig_valid_q;
	logic [ledbpp_pkg::STEP_W-1:0] step_q;
	logic                          playing_q;
	logic [ledbpp_pkg::LEN_W-1:0]  len_q [ledbpp_pkg::NUM_PATTERNS];

	logic                          sel_ok;
	logic [ledbpp_pkg::SLOT_W-1:0] nb_slot;
	logic                          nb_valid;
	logic [ledbpp_pkg::SLOT_W-1:0] ns_slot;
	logic                          ns_valid;
	logic [ledbpp_pkg::STEP_W-1:0] idx0;
	logic                          fire;
	logic                          decr;
	logic                          has_slot;
	logic [ledbpp_pkg::SLOT_W-1:0] slot;
	logic [ledbpp_pkg::LEN_W-1:0]  len;
	logic [ledbpp_pkg::STEP_W-1:0] idx;
	logic [ledbpp_pkg::LEN_W-1:0]  nidx_full;
	logic [ledbpp_pkg::STEP_W-1:0] nidx;
	logic                          fire_ok;
	logic                          new_sig_valid;
	logic                          new_playing;
	logic [ledbpp_pkg::STEP_W-1:0] new_step;
	logic [ledbpp_pkg::LEN_W-1:0]  len_sat;

	assign sel_ok = 32'(sel) < ledbpp_pkg::NUM_PATTERNS;

	always_comb begin
		nb_slot  = base_slot_q;
		nb_valid = base_valid_q;
		ns_slot  = sig_slot_q;
		ns_valid = sig_valid_q;
		idx0     = step_q;
		fire     = 1'b0;
		decr     = 1'b0;
		case (op)
			ledbpp_pkg::OP_TICK: begin
				if (playing_q) begin
					fire = hold_le1;
					decr = !hold_le1;
				end
			end
			ledbpp_pkg::OP_SET_BASE: begin
				nb_slot  = sel;
				nb_valid = !no_pattern && sel_ok;
				if (!sig_valid_q) begin
					idx0 = '0;
					fire = 1'b1;
				end
			end
			ledbpp_pkg::OP_SIGNAL: begin
				if (sig_valid_q || !no_pattern) begin
					ns_slot  = sel;
					ns_valid = !no_pattern && sel_ok;
					idx0     = '0;
					fire     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// The override wins over the base pattern; both only hold in-range slots.
	always_comb begin
		has_slot = ns_valid || nb_valid;
		slot     = ns_valid ? ns_slot : nb_slot;
		len      = len_q[slot];
		idx      = (ledbpp_pkg::LEN_W'(idx0) >= len) ? '0 : idx0;
		nidx_full = ledbpp_pkg::LEN_W'(idx) + ledbpp_pkg::LEN_W'(1);
		nidx      = (nidx_full == len) ? '0 : nidx_full[ledbpp_pkg::STEP_W-1:0];
		fire_ok   = fire && has_slot && (len != '0);

		new_sig_valid = ns_valid;
		new_playing   = playing_q;
		new_step      = idx0;
		plan.act      = ledbpp_pkg::ACT_NONE;
		if (fire_ok) begin
			new_playing = 1'b1;
			new_step    = nidx;
			plan.act    = ledbpp_pkg::ACT_LOAD;
			if (ns_valid && nidx == '0) begin
				new_sig_valid = 1'b0;
			end
		end else if (fire) begin
			new_playing = 1'b0;
			plan.act    = ledbpp_pkg::ACT_OFF;
		end else if (decr) begin
			plan.act = ledbpp_pkg::ACT_DECR;
		end
		plan.playing   = new_playing;
		plan.sig_valid = new_sig_valid;
		plan.step      = new_step;
	end

	assign rd_en   = fire_ok;
	assign rd_addr = {slot, idx};

	assign len_sat = (length_value > ledbpp_pkg::LEN_W'(ledbpp_pkg::MAX_STEPS)) ?
		ledbpp_pkg::LEN_W'(ledbpp_pkg::MAX_STEPS) : length_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_slot_q  <= '0;
			base_valid_q <= 1'b0;
			sig_slot_q   <= '0;
			sig_valid_q  <= 1'b0;
			step_q       <= '0;
			playing_q    <= 1'b0;
			for (int i = 0; i < ledbpp_pkg::NUM_PATTERNS; i++) begin
				len_q[i] <= '0;
			end
		end else if (accept) begin
			base_slot_q  <= nb_slot;
			base_valid_q <= nb_valid;
			sig_slot_q   <= ns_slot;
			sig_valid_q  <= new_sig_valid;
			step_q       <= new_step;
			playing_q    <= new_playing;
			if (op == ledbpp_pkg::OP_WRITE_LEN && sel_ok) begin
				len_q[sel] <= len_sat;
			end
		end
	end

endmodule

// ===== rtl/ledbpp_resolve.sv =====
// Second stage: LED state and hold countdown from the step read out of the store.
module ledbpp_resolve (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  ledbpp_pkg::plan_t            plan_in,
	input  logic                         valid_s1,
	input  logic                         commit,
	input  logic [ledbpp_pkg::DUR_W-1:0] rdata,
	output ledbpp_pkg::res_t             res,
	output logic                         hold_le1
);

	ledbpp_pkg::plan_t             plan_s1;
	logic                          lit_q;
	logic [ledbpp_pkg::HOLD_W-1:0] hold_q;
	logic [ledbpp_pkg::DUR_W-1:0]  mag;
	logic                          raw_lit;
	logic                          new_lit;
	logic                          hold_q_le1;

	assign mag        = ledbpp_pkg::dur_mag(rdata);
	assign raw_lit    = (rdata != '0) && !rdata[ledbpp_pkg::DUR_W-1];
	assign hold_q_le1 = hold_q <= ledbpp_pkg::HOLD_W'(1);

	always_comb begin
		new_lit = lit_q;
		case (plan_s1.act)
			ledbpp_pkg::ACT_LOAD: new_lit = raw_lit;
			ledbpp_pkg::ACT_OFF:  new_lit = 1'b0;
			default:              new_lit = lit_q;
		endcase
	end

	// Countdown state as the front stage sees it once this item is done.
	always_comb begin
		hold_le1 = hold_q_le1;
		if (valid_s1) begin
			case (plan_s1.act)
				ledbpp_pkg::ACT_LOAD:
					hold_le1 = mag < ledbpp_pkg::DUR_W'(2 * ledbpp_pkg::HOLD_DIVISOR);
				ledbpp_pkg::ACT_DECR:
					hold_le1 = hold_q == ledbpp_pkg::HOLD_W'(2);
				default:
					hold_le1 = hold_q_le1;
			endcase
		end
	end

	assign res.lit       = new_lit;
	assign res.playing   = plan_s1.playing;
	assign res.sig_valid = plan_s1.sig_valid;
	assign res.step      = plan_s1.step;

	always_ff @(posedge clk) begin
		if (load) begin
			plan_s1 <= plan_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q  <= 1'b0;
			hold_q <= '0;
		end else if (commit) begin
			lit_q <= new_lit;
			case (plan_s1.act)
				ledbpp_pkg::ACT_LOAD: hold_q <= ledbpp_pkg::hold_ticks(mag);
				ledbpp_pkg::ACT_DECR: hold_q <= hold_q - ledbpp_pkg::HOLD_W'(1);
				default:              hold_q <= hold_q;
			endcase
		end
	end

endmodule
